// ===== hdl/fcsm_pkg.sv =====
// Shared types, constants and glyph functions for the flip counter display.
`timescale 1ns / 1ps

package fcsm_pkg;

  // Segment and value widths
  localparam int SEGMENTS   = 7;
  localparam int VALUE_W    = 14;
  localparam int TIME_W     = 16;
  localparam int BCD_DIGITS = 4;
  localparam int BCD_W      = 4 * BCD_DIGITS;

  typedef logic [SEGMENTS-1:0] pattern_t;
  typedef logic [3:0]          bcd_digit_t;

  // Counter limits and register reset values
  localparam logic [VALUE_W-1:0] TOP_VALUE      = 14'd9999;
  localparam logic [VALUE_W-1:0] RESET_START    = 14'd9000;
  localparam logic [TIME_W-1:0]  RESET_INTERVAL = 16'd20;
  localparam logic [TIME_W-1:0]  RESET_FRAME1   = 16'd150;
  localparam logic [TIME_W-1:0]  RESET_FRAME2   = 16'd110;
  localparam logic [TIME_W-1:0]  RESET_FRAME3   = 16'd150;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_VALUE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_INTERVAL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ONE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TWO      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_THREE    = 3'd4;

  // Display mode codes
  localparam logic [1:0] MODE_UP   = 2'd0;
  localparam logic [1:0] MODE_ANIM = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  // Animation frame codes
  localparam logic [1:0] FRAME_OLD   = 2'd0;
  localparam logic [1:0] FRAME_BLANK = 2'd1;
  localparam logic [1:0] FRAME_BAR   = 2'd2;
  localparam logic [1:0] FRAME_DONE  = 2'd3;

  localparam pattern_t SEG_G = 7'h40;

  // Binary to BCD converter
  localparam int CONV_STEPS = VALUE_W;
  localparam int CONV_CNT_W = $clog2(CONV_STEPS);

  // Per-cycle controls broadcast to every digit cell
  typedef struct packed {
    logic load;
    logic inc;
    logic dec;
  } cell_ctrl_t;

  // Converter status toward the top level
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [BCD_W-1:0] bcd;
  } conv_status_t;

  // Decimal digit to segment pattern, bit 0 is a
  function automatic pattern_t glyph(input bcd_digit_t d);
    unique case (d)
      4'd0:    return 7'h3F;
      4'd1:    return 7'h06;
      4'd2:    return 7'h5B;
      4'd3:    return 7'h4F;
      4'd4:    return 7'h66;
      4'd5:    return 7'h6D;
      4'd6:    return 7'h7D;
      4'd7:    return 7'h07;
      4'd8:    return 7'h7F;
      4'd9:    return 7'h6F;
      default: return 7'h00;
    endcase
  endfunction

  // 180-degree turn of one digit: a<->d, b<->e, c<->f, g stays
  function automatic pattern_t rotate_glyph(input pattern_t p);
    return {p[6], p[2:0], p[5:3]};
  endfunction

endpackage

// ===== hdl/fcsm_bcd_conv.sv =====
// Shift-and-add-3 converter from the binary start value to four BCD digits.
`timescale 1ns / 1ps

module fcsm_bcd_conv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fcsm_pkg::VALUE_W-1:0] value,
  output fcsm_pkg::conv_status_t       status
);

  logic [fcsm_pkg::VALUE_W-1:0]    bin;
  logic [fcsm_pkg::BCD_W-1:0]      bcd;
  logic [fcsm_pkg::BCD_W-1:0]      adj;
  logic [fcsm_pkg::CONV_CNT_W-1:0] cnt;
  logic                            busy;
  logic                            done;

  // Add 3 to every nibble at 5 or above before the shift
  always_comb begin
    for (int i = 0; i < fcsm_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // One bit shifted in per cycle; reset converts the reset start value
  always_ff @(posedge clk) begin
    if (rst) begin
      bin  <= fcsm_pkg::RESET_START;
      bcd  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (start) begin
      bin  <= value;
      bcd  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      bcd <= {adj[fcsm_pkg::BCD_W-2:0], bin[fcsm_pkg::VALUE_W-1]};
      bin <= {bin[fcsm_pkg::VALUE_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (cnt == fcsm_pkg::CONV_CNT_W'(fcsm_pkg::CONV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.bcd  = bcd;

endmodule

// ===== hdl/fcsm_digit_cell.sv =====
// One decimal digit of the counter: carry/borrow up, leading-zero blanking down.
`timescale 1ns / 1ps

module fcsm_digit_cell #(
  parameter bit IS_LAST = 1'b0
) (
  input  logic                   clk,
  input  fcsm_pkg::cell_ctrl_t   ctrl,
  input  fcsm_pkg::bcd_digit_t   load_digit,
  input  logic                   carry_in,
  input  logic                   borrow_in,
  input  logic                   lead_in,
  output logic                   carry_out,
  output logic                   borrow_out,
  output logic                   lead_out,
  output fcsm_pkg::pattern_t     glyph_plain,
  output fcsm_pkg::pattern_t     glyph_rot
);

  fcsm_pkg::bcd_digit_t digit;
  fcsm_pkg::bcd_digit_t digit_next;
  logic                 zero_next;
  logic                 blank;

  // Ripple: this digit rolls when all lower digits roll
  assign carry_out  = carry_in & (digit == 4'd9);
  assign borrow_out = borrow_in & (digit == 4'd0);

  always_comb begin
    priority if (ctrl.load) begin
      digit_next = load_digit;
    end else if (ctrl.inc && carry_in) begin
      digit_next = (digit == 4'd9) ? 4'd0 : digit + 4'd1;
    end else if (ctrl.dec && borrow_in) begin
      digit_next = (digit == 4'd0) ? 4'd9 : digit - 4'd1;
    end else begin
      digit_next = digit;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

  // Leading zeros blank, the units digit always shows
  assign zero_next   = (digit_next == 4'd0);
  assign lead_out    = lead_in & zero_next;
  assign blank       = lead_in & zero_next & !IS_LAST;
  assign glyph_plain = blank ? '0 : fcsm_pkg::glyph(digit_next);
  assign glyph_rot   = fcsm_pkg::rotate_glyph(glyph_plain);

endmodule

// ===== hdl/flip_counter_seven_segment_mux_core.sv =====
// Top level of the multiplexed flip counter: mode control, scan and result register.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-----------------------------------------
//   in      | in  | in_valid / in_stall  | tick
//   out     | out | out_valid / out_stall| digit_enable, segments_n, shown_value,
//           |     |                      | display_mode, rotated_view
//   cfg     | in  | cfg_wr               | cfg_index, cfg_data
//
// One tick beat per clock while in_stall is low; each beat yields one result beat in the cycle after.
// The per-digit cell chain settles carry and blanking within the cycle.
// After reset and after each start_value write the BCD converter shifts in the
// 14 value bits and then loads the digit cells, while in_stall is held high.
// in_stall also follows out_stall when the result register is full.
`timescale 1ns / 1ps

module flip_counter_seven_segment_mux_core #(
  parameter int DIGITS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // tick channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              tick,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        digit_enable,
  output logic [fcsm_pkg::SEGMENTS-1:0]     segments_n,
  output logic [fcsm_pkg::VALUE_W-1:0]      shown_value,
  output logic [1:0]                        display_mode,
  output logic                              rotated_view,
  // configuration
  input  logic                              cfg_wr,
  input  logic [fcsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fcsm_pkg::TIME_W-1:0]       cfg_data
);

  localparam int SCAN_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Configuration registers
  logic [fcsm_pkg::TIME_W-1:0]  count_interval;
  logic [fcsm_pkg::TIME_W-1:0]  frame_one;
  logic [fcsm_pkg::TIME_W-1:0]  frame_two;
  logic [fcsm_pkg::TIME_W-1:0]  frame_three;
  logic [fcsm_pkg::VALUE_W-1:0] start_clamped;
  logic                         start_wr;

  // Counter and mode state
  logic [fcsm_pkg::VALUE_W-1:0] count_value, count_next;
  logic [1:0]                   run_mode, run_mode_next;
  logic                         rotated_now, rotated_now_next;
  logic                         rotated_target, rotated_target_next;
  logic [1:0]                   anim_frame, anim_frame_next;
  logic [fcsm_pkg::TIME_W-1:0]  elapsed, elapsed_next, elapsed_tick;
  logic [fcsm_pkg::TIME_W-1:0]  frame_len;
  logic [SCAN_W-1:0]            scan_index, scan_next;
  fcsm_pkg::pattern_t           patterns [DIGITS];

  // Pattern update controls
  logic                         pat_load;
  logic                         pat_rot;
  logic                         pat_fill;
  fcsm_pkg::pattern_t           pat_fill_value;

  logic                         in_fire;
  fcsm_pkg::cell_ctrl_t         cell_ctrl;
  fcsm_pkg::conv_status_t       conv;

  // Cell chain links
  logic                         carry  [DIGITS];
  logic                         borrow [DIGITS];
  logic                         lead   [DIGITS];
  fcsm_pkg::pattern_t           glyph_plain [DIGITS];
  fcsm_pkg::pattern_t           glyph_rot   [DIGITS];

  assign in_stall = conv.busy | conv.done | (out_valid & out_stall);
  assign in_fire  = in_valid & !in_stall;

  // Start value clamp and converter
  assign start_wr      = cfg_wr && (cfg_index == fcsm_pkg::REG_START_VALUE);
  assign start_clamped = (cfg_data[fcsm_pkg::VALUE_W-1:0] > fcsm_pkg::TOP_VALUE) ?
                         fcsm_pkg::TOP_VALUE : cfg_data[fcsm_pkg::VALUE_W-1:0];

  fcsm_bcd_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (start_wr),
    .value  (start_clamped),
    .status (conv)
  );

  // Row of digit cells, cell k holds the 10^k digit
  assign carry[0]       = 1'b1;
  assign borrow[0]      = 1'b1;
  assign lead[DIGITS-1] = 1'b1;

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    fcsm_pkg::bcd_digit_t ld_digit;
    logic                 c_out;
    logic                 b_out;
    logic                 l_out;

    if (k < fcsm_pkg::BCD_DIGITS) begin : g_ld
      assign ld_digit = conv.bcd[4*k +: 4];
    end else begin : g_ld_zero
      assign ld_digit = '0;
    end

    fcsm_digit_cell #(
      .IS_LAST (k == 0)
    ) u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .load_digit  (ld_digit),
      .carry_in    (carry[k]),
      .borrow_in   (borrow[k]),
      .lead_in     (lead[k]),
      .carry_out   (c_out),
      .borrow_out  (b_out),
      .lead_out    (l_out),
      .glyph_plain (glyph_plain[k]),
      .glyph_rot   (glyph_rot[k])
    );

    if (k < DIGITS - 1) begin : g_up
      assign carry[k+1]  = c_out;
      assign borrow[k+1] = b_out;
    end
    if (k > 0) begin : g_down
      assign lead[k-1] = l_out;
    end
  end

  // Scan position and elapsed time for this beat
  assign scan_next    = (scan_index == SCAN_W'(DIGITS - 1)) ? '0 : scan_index + 1'b1;
  assign elapsed_tick = (tick && (elapsed != '1)) ? elapsed + 1'b1 : elapsed;

  always_comb begin
    unique case (anim_frame)
      fcsm_pkg::FRAME_OLD:   frame_len = frame_one;
      fcsm_pkg::FRAME_BLANK: frame_len = frame_two;
      default:               frame_len = frame_three;
    endcase
  end

  // Mode control: count steps, flip start and animation frames
  always_comb begin
    count_next          = count_value;
    run_mode_next       = run_mode;
    rotated_now_next    = rotated_now;
    rotated_target_next = rotated_target;
    anim_frame_next     = anim_frame;
    elapsed_next        = elapsed;
    cell_ctrl.load      = conv.done;
    cell_ctrl.inc       = 1'b0;
    cell_ctrl.dec       = 1'b0;
    pat_load            = 1'b0;
    pat_rot             = rotated_now;
    pat_fill            = 1'b0;
    pat_fill_value      = '0;

    if (in_fire) begin
      elapsed_next = elapsed_tick;
      unique case (run_mode)
        fcsm_pkg::MODE_UP, fcsm_pkg::MODE_DOWN: begin
          if (elapsed_tick >= count_interval) begin
            elapsed_next = '0;
            if (run_mode == fcsm_pkg::MODE_UP) begin
              if (count_value < fcsm_pkg::TOP_VALUE) begin
                count_next    = count_value + 1'b1;
                cell_ctrl.inc = 1'b1;
                pat_load      = 1'b1;
              end else begin
                run_mode_next       = fcsm_pkg::MODE_ANIM;
                rotated_target_next = 1'b1;
                anim_frame_next     = fcsm_pkg::FRAME_OLD;
                pat_load            = 1'b1;
              end
            end else begin
              if (count_value != '0) begin
                count_next    = count_value - 1'b1;
                cell_ctrl.dec = 1'b1;
                pat_load      = 1'b1;
              end else begin
                run_mode_next       = fcsm_pkg::MODE_ANIM;
                rotated_target_next = 1'b0;
                anim_frame_next     = fcsm_pkg::FRAME_OLD;
                pat_load            = 1'b1;
              end
            end
          end
        end
        fcsm_pkg::MODE_ANIM: begin
          if ((anim_frame != fcsm_pkg::FRAME_DONE) && (elapsed_tick >= frame_len)) begin
            anim_frame_next = anim_frame + 1'b1;
            elapsed_next    = '0;
            unique case (anim_frame)
              fcsm_pkg::FRAME_OLD: begin
                pat_fill       = 1'b1;
                pat_fill_value = '0;
              end
              fcsm_pkg::FRAME_BLANK: begin
                pat_fill       = 1'b1;
                pat_fill_value = fcsm_pkg::SEG_G;
              end
              default: begin
                rotated_now_next = rotated_target;
                pat_load         = 1'b1;
                pat_rot          = rotated_target;
                run_mode_next    = rotated_target ? fcsm_pkg::MODE_DOWN : fcsm_pkg::MODE_UP;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end else if (conv.done && (run_mode != fcsm_pkg::MODE_ANIM)) begin
      // new start value redraws outside the animation
      pat_load = 1'b1;
    end
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_interval <= fcsm_pkg::RESET_INTERVAL;
      frame_one      <= fcsm_pkg::RESET_FRAME1;
      frame_two      <= fcsm_pkg::RESET_FRAME2;
      frame_three    <= fcsm_pkg::RESET_FRAME3;
      count_value    <= fcsm_pkg::RESET_START;
      run_mode       <= fcsm_pkg::MODE_UP;
      rotated_now    <= 1'b0;
      rotated_target <= 1'b0;
      anim_frame     <= fcsm_pkg::FRAME_OLD;
      elapsed        <= '0;
      scan_index     <= '0;
      out_valid      <= 1'b0;
    end else begin
      run_mode       <= run_mode_next;
      rotated_now    <= rotated_now_next;
      rotated_target <= rotated_target_next;
      anim_frame     <= anim_frame_next;
      elapsed        <= elapsed_next;
      if (start_wr) begin
        count_value <= start_clamped;
      end else begin
        count_value <= count_next;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          fcsm_pkg::REG_COUNT_INTERVAL: count_interval <= cfg_data;
          fcsm_pkg::REG_FRAME_ONE:      frame_one      <= cfg_data;
          fcsm_pkg::REG_FRAME_TWO:      frame_two      <= cfg_data;
          fcsm_pkg::REG_FRAME_THREE:    frame_three    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        scan_index <= scan_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Held digit patterns, indexed by scan position
  always_ff @(posedge clk) begin
    for (int p = 0; p < DIGITS; p++) begin
      if (pat_load) begin
        patterns[p] <= pat_rot ? glyph_rot[p] : glyph_plain[DIGITS-1-p];
      end else if (pat_fill) begin
        patterns[p] <= pat_fill_value;
      end
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      digit_enable <= 4'b0001 << scan_next;
      segments_n   <= ~patterns[scan_next];
      shown_value  <= count_next;
      display_mode <= run_mode_next;
      rotated_view <= rotated_now_next;
    end
  end

endmodule
